@@ hdl/fpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpc_pkg: frame pacing clock shared definitions
// Payload types, command / status / action codes and register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

    localparam int TIME_BITS_DEF        = 64;
    localparam int FRAME_COUNT_BITS_DEF = 32;

    localparam int IVL_W = 24;   // interval registers
    localparam int YLD_W = 16;   // yield_every register
    localparam int CFG_W = 24;   // config write data
    localparam int CIX_W = 3;    // config register index

    // commands
    localparam logic [1:0] CMD_POLL   = 2'd0;
    localparam logic [1:0] CMD_RESULT = 2'd1;
    localparam logic [1:0] CMD_PAUSE  = 2'd2;
    localparam logic [1:0] CMD_RESUME = 2'd3;

    // decode status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_EOS = 2'd1;

    // poll actions
    localparam logic [2:0] ACT_PAUSED = 3'd0;
    localparam logic [2:0] ACT_WARMUP = 3'd1;
    localparam logic [2:0] ACT_WAIT   = 3'd2;
    localparam logic [2:0] ACT_DECODE = 3'd3;
    localparam logic [2:0] ACT_NONE   = 3'd4;

    // config register indexes
    localparam logic [CIX_W-1:0] CFG_NORMAL_IVL  = 3'd0;
    localparam logic [CIX_W-1:0] CFG_WARMUP      = 3'd1;
    localparam logic [CIX_W-1:0] CFG_SOFT_START  = 3'd2;
    localparam logic [CIX_W-1:0] CFG_RESUME_MIN  = 3'd3;
    localparam logic [CIX_W-1:0] CFG_SOFT_MIN    = 3'd4;
    localparam logic [CIX_W-1:0] CFG_HANG        = 3'd5;
    localparam logic [CIX_W-1:0] CFG_DIAG_SPACE  = 3'd6;
    localparam logic [CIX_W-1:0] CFG_YIELD_EVERY = 3'd7;

    // register reset values
    localparam logic [IVL_W-1:0] RST_NORMAL_IVL = 24'd33333;
    localparam logic [IVL_W-1:0] RST_WARMUP     = 24'd100000;
    localparam logic [IVL_W-1:0] RST_SOFT_START = 24'd1000000;
    localparam logic [IVL_W-1:0] RST_RESUME_MIN = 24'd50000;
    localparam logic [IVL_W-1:0] RST_SOFT_MIN   = 24'd40000;
    localparam logic [IVL_W-1:0] RST_HANG       = 24'd500000;
    localparam logic [IVL_W-1:0] RST_DIAG_SPACE = 24'd1000000;

    localparam logic [31:0] PAUSED_WAIT = 32'd10000;
    localparam logic [31:0] WARMUP_WAIT = 32'd5000;
    localparam logic [7:0]  ERROR_LIMIT = 8'd10;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] now_time;
        logic [1:0]  decode_status;
    } fpc_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] wait_time;
        logic        soft_start_done;
        logic        stall_seen;
        logic        yield_request;
        logic        stall_diag_due;
        logic        delay_tick;
        logic        stream_end;
        logic        error_state;
        logic        accepted;
    } fpc_out_t;

endpackage

`default_nettype wire

@@ hdl/fpc_if.sv @@
// ----------------------------------------------------------------------------
// fpc_if: frame pacing clock channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if import fpc_pkg::*; ();
    logic    valid;
    logic    ready;
    fpc_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpc_out_if import fpc_pkg::*; ();
    logic     valid;
    logic     ready;
    fpc_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/frame_pacing_clock_core.sv @@
// ----------------------------------------------------------------------------
// frame_pacing_clock_core: video frame pacing against a microsecond time
// Poll / decode result / pause / resume commands, one result beat each.
// ----------------------------------------------------------------------------
// Throughput: one command at a time; the frame-count remainder runs one bit
//   per cycle through the shared adder and makes a good decode result with a
//   nonzero yield_every the slowest command.
// Reset (rst_n low, async): idle, paused, registers at their defaults,
//   all times and counters zero, no result pending.
`default_nettype none

module frame_pacing_clock_core
    import fpc_pkg::*;
#(
    parameter int TIME_BITS        = TIME_BITS_DEF,
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CIX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    fpc_in_if.sink                in_ch,
    fpc_out_if.source             out_ch
);

    localparam int TB    = TIME_BITS;
    localparam int FB    = FRAME_COUNT_BITS;
    localparam int CNT_W = $clog2(FB);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_START     = 4'd1;
    localparam logic [3:0] S_P_WARM    = 4'd2;
    localparam logic [3:0] S_P_SOFT    = 4'd3;
    localparam logic [3:0] S_P_HANG    = 4'd4;
    localparam logic [3:0] S_P_DIAG    = 4'd5;
    localparam logic [3:0] S_P_STALLDL = 4'd6;
    localparam logic [3:0] S_P_DL      = 4'd7;
    localparam logic [3:0] S_P_WAIT    = 4'd8;
    localparam logic [3:0] S_R_DL      = 4'd9;
    localparam logic [3:0] S_R_DIV     = 4'd10;
    localparam logic [3:0] S_M_WARM    = 4'd11;
    localparam logic [3:0] S_M_SOFT    = 4'd12;
    localparam logic [3:0] S_DONE      = 4'd13;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [IVL_W-1:0] normal_ivl_reg, warmup_reg, soft_start_reg;
    logic [IVL_W-1:0] resume_min_reg, soft_min_reg, hang_reg, diag_space_reg;
    logic [YLD_W-1:0] yield_every_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_ivl_reg  <= RST_NORMAL_IVL;
            warmup_reg      <= RST_WARMUP;
            soft_start_reg  <= RST_SOFT_START;
            resume_min_reg  <= RST_RESUME_MIN;
            soft_min_reg    <= RST_SOFT_MIN;
            hang_reg        <= RST_HANG;
            diag_space_reg  <= RST_DIAG_SPACE;
            yield_every_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_IVL:  normal_ivl_reg  <= cfg_data;
                CFG_WARMUP:      warmup_reg      <= cfg_data;
                CFG_SOFT_START:  soft_start_reg  <= cfg_data;
                CFG_RESUME_MIN:  resume_min_reg  <= cfg_data;
                CFG_SOFT_MIN:    soft_min_reg    <= cfg_data;
                CFG_HANG:        hang_reg        <= cfg_data;
                CFG_DIAG_SPACE:  diag_space_reg  <= cfg_data;
                CFG_YIELD_EVERY: yield_every_reg <= cfg_data[YLD_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pacing state, captured command and result under construction
    // ------------------------------------------------------------------
    logic [3:0]       state_reg, state_next;
    logic             paused_reg, paused_next;
    logic [IVL_W-1:0] fi_reg, fi_next;               // current frame interval
    logic [TB-1:0]    deadline_reg, deadline_next;
    logic [TB-1:0]    last_good_reg, last_good_next;
    logic [TB-1:0]    warm_end_reg, warm_end_next;
    logic [TB-1:0]    soft_end_reg, soft_end_next;
    logic [TB-1:0]    last_diag_reg, last_diag_next;
    logic [FB-1:0]    fcount_reg, fcount_next;
    logic [7:0]       err_run_reg, err_run_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [TB-1:0]    now_reg, now_next;
    logic [1:0]       status_reg, status_next;

    // remainder unit: frame count shifted out MSB first
    logic [FB-1:0]    div_src_reg, div_src_next;
    logic [YLD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] bit_idx_reg, bit_idx_next;

    fpc_out_t         res_reg, res_next;
    fpc_out_t         out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Shared adder/subtractor: every time sum, time compare and every
    // remainder trial subtract goes through it. carry = 1 on a subtract
    // means opa >= opb.
    // ------------------------------------------------------------------
    logic [TB-1:0] opa, opb;
    logic          op_sub;
    logic [TB:0]   alu_full;
    logic [TB-1:0] alu_res;
    logic          alu_carry;
    logic [63:0]   alu_res64;
    logic          diff_gt_hang, diff_gt_space;
    logic [YLD_W:0] div_trial;

    assign div_trial = {rem_reg, div_src_reg[FB-1]};

    always_comb
    begin
        opa    = now_reg;
        opb    = '0;
        op_sub = 1'b0;
        case (state_reg)
            S_P_WARM:    begin opb = warm_end_reg;  op_sub = 1'b1; end
            S_P_SOFT:    begin opb = soft_end_reg;  op_sub = 1'b1; end
            S_P_HANG:    begin opb = last_good_reg; op_sub = 1'b1; end
            S_P_DIAG:    begin opb = last_diag_reg; op_sub = 1'b1; end
            S_P_DL:      begin opb = deadline_reg;  op_sub = 1'b1; end
            S_P_WAIT:
            begin
                opa    = deadline_reg;
                opb    = now_reg;
                op_sub = 1'b1;
            end
            S_P_STALLDL: opb = TB'(fi_reg);
            S_R_DL:      opb = TB'(fi_reg);
            S_M_WARM:    opb = TB'(warmup_reg);
            S_M_SOFT:    opb = TB'(soft_start_reg);
            S_R_DIV:
            begin
                opa    = TB'(div_trial);
                opb    = TB'(yield_every_reg);
                op_sub = 1'b1;
            end
            default:     ;
        endcase
    end

    assign alu_full  = {1'b0, opa} + {1'b0, (op_sub ? ~opb : opb)} + {{TB{1'b0}}, op_sub};
    assign alu_res   = alu_full[TB-1:0];
    assign alu_carry = alu_full[TB];
    assign alu_res64 = 64'(alu_res);

    // elapsed time against a 24-bit threshold
    assign diff_gt_hang  = (|alu_res[TB-1:IVL_W]) || (alu_res[IVL_W-1:0] > hang_reg);
    assign diff_gt_space = (|alu_res[TB-1:IVL_W]) || (alu_res[IVL_W-1:0] > diag_space_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic in_fire, out_free;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        paused_next    = paused_reg;
        fi_next        = fi_reg;
        deadline_next  = deadline_reg;
        last_good_next = last_good_reg;
        warm_end_next  = warm_end_reg;
        soft_end_next  = soft_end_reg;
        last_diag_next = last_diag_reg;
        fcount_next    = fcount_reg;
        err_run_next   = err_run_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        status_next    = status_reg;
        div_src_next   = div_src_reg;
        rem_next       = rem_reg;
        bit_idx_next   = bit_idx_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next    = in_ch.data.cmd;
                    now_next    = in_ch.data.now_time[TB-1:0];
                    status_next = in_ch.data.decode_status;
                    state_next  = S_START;
                end
            end

            S_START:
            begin
                res_next        = '0;
                res_next.action = ACT_NONE;
                state_next      = S_DONE;
                case (cmd_reg)
                    CMD_POLL:
                    begin
                        if (paused_reg)
                        begin
                            res_next.action    = ACT_PAUSED;
                            res_next.wait_time = PAUSED_WAIT;
                        end
                        else
                        begin
                            state_next = S_P_WARM;
                        end
                    end
                    CMD_RESULT:
                    begin
                        if (status_reg == ST_OK)
                        begin
                            last_good_next = now_reg;
                            fcount_next    = fcount_reg + FB'(1);
                            err_run_next   = '0;
                            state_next     = S_R_DL;
                        end
                        else if (status_reg == ST_EOS)
                        begin
                            deadline_next       = now_reg;
                            last_good_next      = now_reg;
                            res_next.stream_end = 1'b1;
                        end
                        else
                        begin
                            // any other status counts as an error
                            if (err_run_reg != 8'hFF)
                                err_run_next = err_run_reg + 8'd1;
                            res_next.error_state = (err_run_next > ERROR_LIMIT);
                        end
                    end
                    CMD_PAUSE:
                    begin
                        paused_next = 1'b1;
                    end
                    default:
                    begin
                        // resume; rejected while the normal interval is zero
                        if (normal_ivl_reg != '0)
                        begin
                            last_good_next    = now_reg;
                            last_diag_next    = '0;
                            fi_next           = (normal_ivl_reg < resume_min_reg) ?
                                                resume_min_reg : normal_ivl_reg;
                            paused_next       = 1'b0;
                            res_next.accepted = 1'b1;
                            state_next        = S_M_WARM;
                        end
                    end
                endcase
            end

            S_P_WARM:
            begin
                if (!alu_carry)
                begin
                    res_next.action    = ACT_WARMUP;
                    res_next.wait_time = WARMUP_WAIT;
                    state_next         = S_DONE;
                end
                else
                begin
                    state_next = S_P_SOFT;
                end
            end

            S_P_SOFT:
            begin
                if (!alu_carry)
                begin
                    if (fi_reg < soft_min_reg)
                        fi_next = soft_min_reg;
                end
                else if (fi_reg != normal_ivl_reg)
                begin
                    fi_next                  = normal_ivl_reg;
                    res_next.soft_start_done = 1'b1;
                end
                state_next = S_P_HANG;
            end

            S_P_HANG:
            begin
                if (diff_gt_hang)
                begin
                    res_next.stall_seen    = 1'b1;
                    res_next.yield_request = 1'b1;
                    state_next             = S_P_DIAG;
                end
                else
                begin
                    state_next = S_P_DL;
                end
            end

            S_P_DIAG:
            begin
                if (diff_gt_space)
                begin
                    last_diag_next          = now_reg;
                    res_next.stall_diag_due = 1'b1;
                end
                state_next = S_P_STALLDL;
            end

            S_P_STALLDL:
            begin
                deadline_next      = alu_res;
                res_next.action    = ACT_WAIT;
                res_next.wait_time = 32'(fi_reg);
                state_next         = S_DONE;
            end

            S_P_DL:
            begin
                if (alu_carry)
                begin
                    res_next.action = ACT_DECODE;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_P_WAIT;
                end
            end

            S_P_WAIT:
            begin
                res_next.action    = ACT_WAIT;
                res_next.wait_time = (|alu_res64[63:32]) ? 32'hFFFF_FFFF : alu_res64[31:0];
                state_next         = S_DONE;
            end

            S_R_DL:
            begin
                deadline_next = alu_res;
                div_src_next  = fcount_reg;
                rem_next      = '0;
                bit_idx_next  = CNT_W'(FB - 1);
                state_next    = (yield_every_reg == '0) ? S_DONE : S_R_DIV;
            end

            S_R_DIV:
            begin
                // restoring remainder step, one count bit per cycle
                if (alu_carry)
                    rem_next = alu_res[YLD_W-1:0];
                else
                    rem_next = div_trial[YLD_W-1:0];
                div_src_next = {div_src_reg[FB-2:0], 1'b0};
                if (bit_idx_reg == '0)
                begin
                    res_next.delay_tick = (rem_next == '0);
                    state_next          = S_DONE;
                end
                else
                begin
                    bit_idx_next = bit_idx_reg - CNT_W'(1);
                end
            end

            S_M_WARM:
            begin
                warm_end_next = alu_res;
                deadline_next = alu_res;
                state_next    = S_M_SOFT;
            end

            S_M_SOFT:
            begin
                soft_end_next = alu_res;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // hold the result here until the output register frees up
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            paused_reg    <= 1'b1;
            fi_reg        <= RST_NORMAL_IVL;
            deadline_reg  <= '0;
            last_good_reg <= '0;
            warm_end_reg  <= '0;
            soft_end_reg  <= '0;
            last_diag_reg <= '0;
            fcount_reg    <= '0;
            err_run_reg   <= '0;
            bit_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            paused_reg    <= paused_next;
            fi_reg        <= fi_next;
            deadline_reg  <= deadline_next;
            last_good_reg <= last_good_next;
            warm_end_reg  <= warm_end_next;
            soft_end_reg  <= soft_end_next;
            last_diag_reg <= last_diag_next;
            fcount_reg    <= fcount_next;
            err_run_reg   <= err_run_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        now_reg     <= now_next;
        status_reg  <= status_next;
        div_src_reg <= div_src_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

`ifndef SYNTHESIS
    // an accepted command beat is decoded on the very next cycle
    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_START))
        else $error("command beat not decoded after acceptance");

    // the remainder loop only runs with a nonzero yield interval
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R_DIV) |-> (yield_every_reg != '0))
        else $error("remainder step with zero yield interval");

    // a result carrying a decode-result or resume flag is never a poll answer
    a_flags_non_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.data.error_state || out_ch.data.delay_tick ||
                          out_ch.data.stream_end || out_ch.data.accepted))
        |-> (out_ch.data.action == ACT_NONE))
        else $error("decode or resume flag on a poll result");

    // a new result is only loaded when the previous one has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

@@ tb/tb_frame_pacing_clock_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_pacing_clock_core: self-checking bench for the frame pacing core
// Drives poll / decode result / pause / resume beats with random gaps on both
// channels, predicts every result beat from a shadow copy of the pacing state
// and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------

module tb_frame_pacing_clock_core;
    import fpc_pkg::*;

    localparam int          NUM_REGS     = 8;
    localparam int          DRAIN_CYCLES = 48;        // longer than the slowest command
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam logic [1:0]  ST_ERR       = 2'd2;      // decode error
    localparam logic [1:0]  ST_BAD       = 2'd3;      // unknown status, counts as error
    localparam logic [63:0] TIME_TOP     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CIX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    fpc_in_if  in_ch ();
    fpc_out_if out_ch ();

    frame_pacing_clock_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the pacing state and of the register file
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] reg_val [NUM_REGS];
    logic             pace_paused;
    logic [IVL_W-1:0] pace_ivl;          // current frame interval
    logic [63:0]      pace_deadline;
    logic [63:0]      pace_last_good;
    logic [63:0]      pace_warm_end;
    logic [63:0]      pace_soft_end;
    logic [63:0]      pace_last_diag;
    logic [31:0]      pace_frames;
    logic [7:0]       pace_err_run;

    fpc_out_t         pacing_answers [$];   // result beats still owed by the core
    fpc_out_t         last_pred;            // answer to the most recent command beat
    fpc_out_t         seen_exp;
    int               mismatches = 0;
    int               cycles     = 0;
    int               src_idle_pct;
    int               snk_idle_pct;
    logic [63:0]      clock_now;

    task automatic pace_reset();
        reg_val[CFG_NORMAL_IVL]  = RST_NORMAL_IVL;
        reg_val[CFG_WARMUP]      = RST_WARMUP;
        reg_val[CFG_SOFT_START]  = RST_SOFT_START;
        reg_val[CFG_RESUME_MIN]  = RST_RESUME_MIN;
        reg_val[CFG_SOFT_MIN]    = RST_SOFT_MIN;
        reg_val[CFG_HANG]        = RST_HANG;
        reg_val[CFG_DIAG_SPACE]  = RST_DIAG_SPACE;
        reg_val[CFG_YIELD_EVERY] = '0;
        pace_paused    = 1'b1;
        pace_ivl       = RST_NORMAL_IVL;
        pace_deadline  = '0;
        pace_last_good = '0;
        pace_warm_end  = '0;
        pace_soft_end  = '0;
        pace_last_diag = '0;
        pace_frames    = '0;
        pace_err_run   = '0;
    endtask

    // Advance the shadow state by one command beat and return its answer.
    function automatic fpc_out_t pace_step(fpc_in_t b);
        fpc_out_t    r;
        logic [63:0] now;
        logic [63:0] gap;
        logic [31:0] every;
        r        = '0;
        r.action = ACT_NONE;
        now      = b.now_time;
        every    = {16'd0, reg_val[CFG_YIELD_EVERY][YLD_W-1:0]};
        case (b.cmd)
            CMD_POLL:
            begin
                if (pace_paused)
                begin
                    r.action    = ACT_PAUSED;
                    r.wait_time = PAUSED_WAIT;
                end
                else if (pace_warm_end > now)
                begin
                    r.action    = ACT_WARMUP;
                    r.wait_time = WARMUP_WAIT;
                end
                else
                begin
                    // soft start holds a floor; once over, snap back to normal
                    if (pace_soft_end > now)
                    begin
                        if (pace_ivl < reg_val[CFG_SOFT_MIN])
                            pace_ivl = reg_val[CFG_SOFT_MIN];
                    end
                    else if (pace_ivl != reg_val[CFG_NORMAL_IVL])
                    begin
                        pace_ivl          = reg_val[CFG_NORMAL_IVL];
                        r.soft_start_done = 1'b1;
                    end
                    if (now - pace_last_good > {40'd0, reg_val[CFG_HANG]})
                    begin
                        r.stall_seen    = 1'b1;
                        r.yield_request = 1'b1;
                        if (now - pace_last_diag > {40'd0, reg_val[CFG_DIAG_SPACE]})
                        begin
                            pace_last_diag   = now;
                            r.stall_diag_due = 1'b1;
                        end
                        pace_deadline = now + {40'd0, pace_ivl};
                        r.action      = ACT_WAIT;
                        r.wait_time   = {8'd0, pace_ivl};
                    end
                    else if (now >= pace_deadline)
                        r.action = ACT_DECODE;
                    else
                    begin
                        gap         = pace_deadline - now;
                        r.action    = ACT_WAIT;
                        r.wait_time = (gap > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap[31:0];
                    end
                end
            end
            CMD_RESULT:
            begin
                case (b.decode_status)
                    ST_OK:
                    begin
                        pace_last_good = now;
                        pace_frames    = pace_frames + 32'd1;
                        pace_err_run   = '0;
                        pace_deadline  = now + {40'd0, pace_ivl};
                        if (every != 0 && (pace_frames % every) == 0)
                            r.delay_tick = 1'b1;
                    end
                    ST_EOS:
                    begin
                        pace_deadline  = now;
                        pace_last_good = now;
                        r.stream_end   = 1'b1;
                    end
                    default:
                    begin
                        if (pace_err_run != 8'hFF)
                            pace_err_run = pace_err_run + 8'd1;
                        if (pace_err_run > ERROR_LIMIT)
                            r.error_state = 1'b1;
                    end
                endcase
            end
            CMD_PAUSE:
                pace_paused = 1'b1;
            default:
            begin
                // resume is refused outright with a zero normal interval
                if (reg_val[CFG_NORMAL_IVL] != 0)
                begin
                    pace_warm_end  = now + {40'd0, reg_val[CFG_WARMUP]};
                    pace_soft_end  = now + {40'd0, reg_val[CFG_SOFT_START]};
                    pace_deadline  = pace_warm_end;
                    pace_last_good = now;
                    pace_last_diag = '0;
                    pace_ivl       = (reg_val[CFG_NORMAL_IVL] < reg_val[CFG_RESUME_MIN])
                                     ? reg_val[CFG_RESUME_MIN] : reg_val[CFG_NORMAL_IVL];
                    pace_paused    = 1'b0;
                    r.accepted     = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command side. valid is left high after a beat so that back-to-back
    // beats need no drop; settle() lowers it when traffic stops.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] cmd, input logic [63:0] t,
                             input logic [1:0] st);
        fpc_in_t b;
        b.cmd           = cmd;
        b.now_time      = t;
        b.decode_status = st;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        last_pred = pace_step(b);
        pacing_answers.push_back(last_pred);
    endtask

    // Stop sending, wait for every owed result beat, then let the core go idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pacing_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all registers back to back; only called with the core idle.
    task automatic program_regs(input logic [CFG_W-1:0] vals [NUM_REGS]);
        for (int k = 0; k < NUM_REGS; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CIX_W'(k);
            cfg_data  <= vals[k];
            @(posedge clk);
            reg_val[k] = (k == CFG_YIELD_EVERY) ? {8'd0, vals[k][YLD_W-1:0]} : vals[k];
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (pacing_answers.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, out_ch.data);
                    mismatches++;
                end
                else
                begin
                    seen_exp = pacing_answers.pop_front();
                    check_field("action", seen_exp.action, out_ch.data.action);
                    check_field("wait_time", seen_exp.wait_time, out_ch.data.wait_time);
                    check_field("soft_start_done", seen_exp.soft_start_done,
                                out_ch.data.soft_start_done);
                    check_field("stall_seen", seen_exp.stall_seen, out_ch.data.stall_seen);
                    check_field("yield_request", seen_exp.yield_request,
                                out_ch.data.yield_request);
                    check_field("stall_diag_due", seen_exp.stall_diag_due,
                                out_ch.data.stall_diag_due);
                    check_field("delay_tick", seen_exp.delay_tick, out_ch.data.delay_tick);
                    check_field("stream_end", seen_exp.stream_end, out_ch.data.stream_end);
                    check_field("error_state", seen_exp.error_state, out_ch.data.error_state);
                    check_field("accepted", seen_exp.accepted, out_ch.data.accepted);
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests (starting from the register defaults after reset)
    // ------------------------------------------------------------------------

    // Walk one playback session through every poll action and the time corners.
    task automatic test_playback_session();
        logic [63:0] t;
        send_beat(CMD_POLL,   64'd0, ST_OK);               // paused right after reset
        send_beat(CMD_RESULT, 64'd5, ST_OK);               // good decode while paused
        send_beat(CMD_RESULT, 64'd6, ST_BAD);              // unknown status = error
        send_beat(CMD_RESUME, 64'd1000, ST_ERR);           // interval raised to resume floor
        send_beat(CMD_POLL,   64'd2000, ST_OK);            // inside warm-up
        send_beat(CMD_POLL,   64'd101000, ST_OK);          // deadline reached exactly
        send_beat(CMD_RESULT, 64'd101500, ST_OK);
        send_beat(CMD_POLL,   64'd1200000, ST_OK);         // soft start over + stall + diag
        send_beat(CMD_RESULT, 64'd1300000, ST_EOS);
        t = 64'd2000000;
        send_beat(CMD_RESULT, t, ST_OK);
        send_beat(CMD_POLL,   t + (64'd1 << 40), ST_OK);   // stall pushes deadline far out
        send_beat(CMD_POLL,   t + 64'd1, ST_OK);           // wait saturates at 32 bits
        send_beat(CMD_RESUME, TIME_TOP - 64'd9, ST_OK);    // warm-up end wraps past zero
        send_beat(CMD_POLL,   TIME_TOP - 64'd4, ST_OK);
        settle();
    endtask

    // More than ten errors in a row raise the error state.
    task automatic test_error_run();
        for (int k = 0; k < 11; k++)
            send_beat(CMD_RESULT, 64'd3000000 + 64'(k), (k == 4) ? ST_BAD : ST_ERR);
        settle();
    endtask

    // Zero normal interval refuses resume; yield tick every third good frame.
    task automatic test_refused_resume_and_yield();
        logic [CFG_W-1:0] vals [NUM_REGS];
        vals                  = reg_val;
        vals[CFG_NORMAL_IVL]  = '0;
        vals[CFG_YIELD_EVERY] = 24'hA50003;   // upper bits are not part of the register
        program_regs(vals);
        send_beat(CMD_RESUME, 64'd4000000, ST_OK);
        for (int k = 0; k < 3; k++)
            send_beat(CMD_RESULT, 64'd4000100 + 64'(k), ST_OK);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------------
    task automatic load_random_regs(input int kind);
        logic [CFG_W-1:0] vals [NUM_REGS];
        vals[CFG_NORMAL_IVL]  = CFG_W'($urandom_range(1000, 60000));
        vals[CFG_WARMUP]      = CFG_W'($urandom_range(0, 200000));
        vals[CFG_SOFT_START]  = CFG_W'($urandom_range(0, 2000000));
        vals[CFG_RESUME_MIN]  = CFG_W'($urandom_range(0, 80000));
        vals[CFG_SOFT_MIN]    = CFG_W'($urandom_range(0, 80000));
        vals[CFG_HANG]        = CFG_W'($urandom_range(1000, 1000000));
        vals[CFG_DIAG_SPACE]  = CFG_W'($urandom_range(0, 2000000));
        vals[CFG_YIELD_EVERY] = {8'($urandom), 16'($urandom_range(1, 7))};
        case (kind)
            1:
            begin
                // floor of every register: any time gap is a stall
                for (int k = 0; k < NUM_REGS; k++)
                    vals[k] = '0;
                vals[CFG_NORMAL_IVL]  = 24'd1;
                vals[CFG_YIELD_EVERY] = {8'($urandom), 16'd0};
            end
            2:
            begin
                for (int k = 0; k < NUM_REGS; k++)
                    vals[k] = '1;
            end
            3:
                vals[CFG_NORMAL_IVL] = '0;   // every resume refused
            default: ;
        endcase
        program_regs(vals);
    endtask

    // Mostly well-formed sessions: resume when paused, decode when told to,
    // poll again around the suggested wait; mixed with pauses, stray results,
    // error bursts and time jumps.
    task automatic run_paced_traffic(input int n_items);
        int         i;
        int         pick;
        int         roll;
        int         burst;
        logic [1:0] st;
        i = 0;
        while (i < n_items)
        begin
            roll = $urandom_range(0, 99);
            if (last_pred.action == ACT_WAIT && roll < 50)
            begin
                clock_now = clock_now + last_pred.wait_time;
                if (roll < 10)
                    clock_now = clock_now - 64'd1;   // one short of the deadline
            end
            else if (roll < 75)
                clock_now = clock_now + $urandom_range(0, 60000);
            else if (roll < 92)
                clock_now = clock_now + $urandom_range(0, 3000000);
            else if (roll < 97)
                clock_now = clock_now + $urandom_range(0, 1 << 25);
            else if (roll < 99)
                clock_now = {$urandom, $urandom};
            else
                clock_now = clock_now - $urandom_range(1, 1000);

            pick = $urandom_range(0, 99);
            st   = 2'($urandom);
            if (pace_paused && pick < 75)
                send_beat(CMD_RESUME, clock_now, st);
            else if (last_pred.action == ACT_DECODE && pick < 85)
            begin
                roll = $urandom_range(0, 99);
                st   = (roll < 80) ? ST_OK : (roll < 87) ? ST_EOS :
                       (roll < 97) ? ST_ERR : ST_BAD;
                send_beat(CMD_RESULT, clock_now, st);
            end
            else if (pick < 3)
                send_beat(CMD_PAUSE, clock_now, st);
            else if (pick < 6)
                send_beat(CMD_RESUME, clock_now, st);
            else if (pick < 8)
            begin
                // error burst; the long ones saturate the error run
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(260, 300)
                                                    : $urandom_range(2, 14);
                repeat (burst)
                begin
                    clock_now = clock_now + $urandom_range(0, 5000);
                    send_beat(CMD_RESULT, clock_now,
                              ($urandom_range(0, 3) == 0) ? ST_BAD : ST_ERR);
                end
                i = i + burst - 1;
            end
            else if (pick < 12)
                send_beat(CMD_RESULT, clock_now, st);
            else
                send_beat(CMD_POLL, clock_now, st);
            i++;
            // now and then hold off until the core has answered everything
            if ($urandom_range(0, 299) == 0)
                settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        src_idle_pct = 30;
        snk_idle_pct = 70;
        last_pred    = '0;
        pace_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_playback_session();
        test_error_run();
        test_refused_resume_and_yield();

        clock_now = 64'd5000000;
        for (int mode = 0; mode < 3; mode++)
        begin
            // sender 30 / receiver 70, then swapped, then no idling at all
            src_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 70 : 0;
            snk_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 30 : 0;
            load_random_regs((mode == 0) ? 1 : (mode == 1) ? 2 : 3);
            run_paced_traffic(330);
            settle();
            load_random_regs(0);
            run_paced_traffic(330);
            settle();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
